### rtl/kqt_pkg.sv
// kqt_pkg: table size, index width, action and status codes for the quota table
// used by keyed_quota_table_core; no dependencies
`default_nettype none

package kqt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [2:0] ACT_SET       = 3'd0;
  localparam logic [2:0] ACT_CHK_INODE = 3'd1;
  localparam logic [2:0] ACT_CHK_BLK   = 3'd2;
  localparam logic [2:0] ACT_ADD_INODE = 3'd3;
  localparam logic [2:0] ACT_RM_INODE  = 3'd4;
  localparam logic [2:0] ACT_ADD_BLK   = 3'd5;
  localparam logic [2:0] ACT_RM_BLK    = 3'd6;
  localparam logic [2:0] ACT_GET       = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EXCEEDED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

endpackage

`default_nettype wire

### rtl/keyed_quota_table_core.sv
// keyed_quota_table_core: per-owner inode/block quota table with a scan sequencer
// and one shared 18-bit add/subtract unit; depends on kqt_pkg
`default_nettype none

// usage
//   request channel: in_valid_i/in_ready_o with action, owner id, new limits and a
//   block amount; one result per request on out_valid_o/out_ready_i
//   in_ready_o is high only while the sequencer is idle
//   a request walks the table one entry per cycle looking for the lowest active
//   entry of the owner and the lowest free slot, loads the matching entry, runs
//   the add/subtract unit (for the block check it first forms used + amount and
//   then compares it with the limit), writes back, and hands the result to the
//   output register; the next request is taken only after that hand-over
//   the result sits in an output register; while the receiver stalls the block
//   still takes and works on the next request, and holds before delivering it
//   until the previous result has been taken
//   reset clears all valid bits, so the table starts empty; entry contents are
//   not cleared and never reach a result before being written
module keyed_quota_table_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [15:0] owner_id_i,
  input  wire logic [15:0] inode_limit_in_i,
  input  wire logic [15:0] block_limit_in_i,
  input  wire logic [15:0] block_amount_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic             found_o,
  output logic [15:0]      inode_limit_out_o,
  output logic [15:0]      block_limit_out_o,
  output logic [15:0]      inodes_used_out_o,
  output logic [15:0]      blocks_used_out_o
);

  localparam int N = kqt_pkg::TABLE_ENTRIES;
  localparam int IW = kqt_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LOAD,
    S_EXEC,
    S_DONE
  } state_e;

  state_e state_q;

  // table storage
  logic [N-1:0] slot_valid_q;
  logic [15:0]  slot_owner_q       [N];
  logic [15:0]  slot_inode_limit_q [N];
  logic [15:0]  slot_block_limit_q [N];
  logic [15:0]  slot_inodes_used_q [N];
  logic [15:0]  slot_blocks_used_q [N];

  // captured request
  logic [2:0]  act_q;
  logic [15:0] who_q;
  logic [15:0] ilim_q;
  logic [15:0] blim_q;
  logic [15:0] amt_q;

  // scan results
  logic [IW-1:0] scan_idx_q;
  logic          hit_q;
  logic [IW-1:0] hit_idx_q;
  logic          free_q;
  logic [IW-1:0] free_idx_q;

  // loaded entry and work registers
  logic [15:0] e_il_q;
  logic [15:0] e_bl_q;
  logic [15:0] e_iu_q;
  logic [15:0] e_bu_q;
  logic        step_q;
  logic [16:0] tmp_q;
  logic [1:0]  pend_status_q;

  // output register
  logic        out_valid_q;
  logic [1:0]  status_q;
  logic        found_q;
  logic [15:0] il_out_q;
  logic [15:0] bl_out_q;
  logic [15:0] iu_out_q;
  logic [15:0] bu_out_q;

  // shared add/subtract unit
  logic [17:0] alu_a;
  logic [17:0] alu_b;
  logic        alu_sub;
  logic [17:0] alu_r;
  logic        alu_borrow;
  logic [15:0] alu_sat;

  logic scan_match;
  logic scan_empty;
  logic scan_last;
  logic exec_last;
  logic out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  assign scan_match = slot_valid_q[scan_idx_q] && (slot_owner_q[scan_idx_q] == who_q);
  assign scan_empty = !slot_valid_q[scan_idx_q];
  assign scan_last  = (scan_idx_q == IW'(N - 1));

  // block check needs a second pass through the unit
  assign exec_last = !((act_q == kqt_pkg::ACT_CHK_BLK) && !step_q);

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (act_q)
      kqt_pkg::ACT_CHK_INODE: begin
        alu_a   = {2'b00, e_iu_q};
        alu_b   = {2'b00, e_il_q};
        alu_sub = 1'b1;
      end
      kqt_pkg::ACT_CHK_BLK: begin
        if (!step_q) begin
          alu_a = {2'b00, e_bu_q};
          alu_b = {2'b00, amt_q};
        end else begin
          // limit - (used + amount) borrows when the sum exceeds the limit
          alu_a   = {2'b00, e_bl_q};
          alu_b   = {1'b0, tmp_q};
          alu_sub = 1'b1;
        end
      end
      kqt_pkg::ACT_ADD_INODE: begin
        alu_a = {2'b00, e_iu_q};
        alu_b = 18'd1;
      end
      kqt_pkg::ACT_RM_INODE: begin
        alu_a   = {2'b00, e_iu_q};
        alu_b   = 18'd1;
        alu_sub = 1'b1;
      end
      kqt_pkg::ACT_ADD_BLK: begin
        alu_a = {2'b00, e_bu_q};
        alu_b = {2'b00, amt_q};
      end
      kqt_pkg::ACT_RM_BLK: begin
        alu_a   = {2'b00, e_bu_q};
        alu_b   = {2'b00, amt_q};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_r      = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign alu_borrow = alu_r[17];

  // saturate additions at all ones, floor subtractions at zero
  always_comb begin
    if (alu_sub) begin
      alu_sat = alu_borrow ? 16'h0000 : alu_r[15:0];
    end else begin
      alu_sat = alu_r[16] ? 16'hFFFF : alu_r[15:0];
    end
  end

  // sequencer, valid bits and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      slot_valid_q  <= '0;
      out_valid_q   <= 1'b0;
      scan_idx_q    <= '0;
      hit_q         <= 1'b0;
      hit_idx_q     <= '0;
      free_q        <= 1'b0;
      free_idx_q    <= '0;
      step_q        <= 1'b0;
      pend_status_q <= kqt_pkg::ST_OK;
    end else begin
      // in S_DONE a taken result is replaced by the next one below
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_q      <= action_i;
            who_q      <= owner_id_i;
            ilim_q     <= inode_limit_in_i;
            blim_q     <= block_limit_in_i;
            amt_q      <= block_amount_i;
            scan_idx_q <= '0;
            hit_q      <= 1'b0;
            free_q     <= 1'b0;
            state_q    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // keep the lowest-index match and the lowest free slot
          if (scan_match && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= scan_idx_q;
          end
          if (scan_empty && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= scan_idx_q;
          end
          if (scan_last) begin
            state_q <= S_LOAD;
          end else begin
            scan_idx_q <= scan_idx_q + IW'(1);
          end
        end
        S_LOAD: begin
          e_il_q  <= slot_inode_limit_q[hit_idx_q];
          e_bl_q  <= slot_block_limit_q[hit_idx_q];
          e_iu_q  <= slot_inodes_used_q[hit_idx_q];
          e_bu_q  <= slot_blocks_used_q[hit_idx_q];
          step_q  <= 1'b0;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          case (act_q) inside
            kqt_pkg::ACT_SET: begin
              if (!hit_q && free_q) begin
                slot_valid_q[free_idx_q] <= 1'b1;
              end
              pend_status_q <= (!hit_q && !free_q) ? kqt_pkg::ST_FULL : kqt_pkg::ST_OK;
            end
            kqt_pkg::ACT_CHK_INODE: begin
              pend_status_q <= (hit_q && (e_il_q != 16'h0000) && !alu_borrow) ?
                               kqt_pkg::ST_EXCEEDED : kqt_pkg::ST_OK;
            end
            kqt_pkg::ACT_CHK_BLK: begin
              tmp_q         <= alu_r[16:0];
              pend_status_q <= (step_q && hit_q && (e_bl_q != 16'h0000) && alu_borrow) ?
                               kqt_pkg::ST_EXCEEDED : kqt_pkg::ST_OK;
            end
            default: begin
              pend_status_q <= kqt_pkg::ST_OK;
            end
          endcase
          step_q <= 1'b1;
          if (exec_last) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          // wait for the previous result to leave
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= pend_status_q;
            found_q     <= hit_q;
            if ((act_q == kqt_pkg::ACT_GET) && hit_q) begin
              il_out_q <= e_il_q;
              bl_out_q <= e_bl_q;
              iu_out_q <= e_iu_q;
              bu_out_q <= e_bu_q;
            end else begin
              il_out_q <= '0;
              bl_out_q <= '0;
              iu_out_q <= '0;
              bu_out_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // entry write-back
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      case (act_q) inside
        kqt_pkg::ACT_SET: begin
          if (hit_q) begin
            slot_inode_limit_q[hit_idx_q] <= ilim_q;
            slot_block_limit_q[hit_idx_q] <= blim_q;
          end else if (free_q) begin
            slot_owner_q[free_idx_q]       <= who_q;
            slot_inode_limit_q[free_idx_q] <= ilim_q;
            slot_block_limit_q[free_idx_q] <= blim_q;
            slot_inodes_used_q[free_idx_q] <= '0;
            slot_blocks_used_q[free_idx_q] <= '0;
          end
        end
        kqt_pkg::ACT_ADD_INODE, kqt_pkg::ACT_RM_INODE: begin
          if (hit_q) begin
            slot_inodes_used_q[hit_idx_q] <= alu_sat;
          end
        end
        kqt_pkg::ACT_ADD_BLK, kqt_pkg::ACT_RM_BLK: begin
          if (hit_q) begin
            slot_blocks_used_q[hit_idx_q] <= alu_sat;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign found_o           = found_q;
  assign inode_limit_out_o = il_out_q;
  assign block_limit_out_o = bl_out_q;
  assign inodes_used_out_o = iu_out_q;
  assign blocks_used_out_o = bu_out_q;

endmodule

`default_nettype wire

### bench/tb_keyed_quota_table_core.sv
// tb_keyed_quota_table_core: self-checking bench for the per-owner quota table, with
// directed and random requests, random idling on both sides, and an in-bench predictor
// depends on kqt_pkg and keyed_quota_table_core
`default_nettype none

module tb_keyed_quota_table_core;

  // one request as it enters the block
  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] owner;
    logic [15:0] inode_limit;
    logic [15:0] block_limit;
    logic [15:0] amount;
  } quota_req_t;

  // one result as it leaves the block
  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [15:0] inode_limit;
    logic [15:0] block_limit;
    logic [15:0] inodes_used;
    logic [15:0] blocks_used;
  } quota_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  action_i;
  logic [15:0] owner_id_i;
  logic [15:0] inode_limit_in_i;
  logic [15:0] block_limit_in_i;
  logic [15:0] block_amount_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic        found_o;
  logic [15:0] inode_limit_out_o;
  logic [15:0] block_limit_out_o;
  logic [15:0] inodes_used_out_o;
  logic [15:0] blocks_used_out_o;

  keyed_quota_table_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .owner_id_i        (owner_id_i),
    .inode_limit_in_i  (inode_limit_in_i),
    .block_limit_in_i  (block_limit_in_i),
    .block_amount_i    (block_amount_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .found_o           (found_o),
    .inode_limit_out_o (inode_limit_out_o),
    .block_limit_out_o (block_limit_out_o),
    .inodes_used_out_o (inodes_used_out_o),
    .blocks_used_out_o (blocks_used_out_o)
  );

  // shadow copy of the quota table, updated in request order
  logic        shadow_valid       [kqt_pkg::TABLE_ENTRIES];
  logic [15:0] shadow_owner       [kqt_pkg::TABLE_ENTRIES];
  logic [15:0] shadow_inode_limit [kqt_pkg::TABLE_ENTRIES];
  logic [15:0] shadow_block_limit [kqt_pkg::TABLE_ENTRIES];
  logic [15:0] shadow_inodes_used [kqt_pkg::TABLE_ENTRIES];
  logic [15:0] shadow_blocks_used [kqt_pkg::TABLE_ENTRIES];

  // results owed by the block, oldest first
  quota_result_t pending_results[$];

  // owners that random traffic mostly addresses; more than the table holds,
  // so the table fills up and later sets of new owners hit the full case
  logic [15:0] owner_pool [20];

  int  mismatches;
  int  hold_cycles;   // receiver hold-off, counted down by the receiver itself
  bit  no_idle;       // suppresses random gaps on both sides
  int  n_requests;
  int  n_results;
  int  n_exceeded;
  int  n_full;
  int  n_found;

  // clock and the single reset at the start of the run
  always #6 clk_i = ~clk_i;

  // quota table predictor: applies one request to the shadow table and
  // returns what the block must report for it
  function automatic quota_result_t predict_quota(quota_req_t req);
    quota_result_t res;
    int            hit;
    int            free_slot;
    logic [16:0]   wide_sum;

    res       = '0;
    res.status = kqt_pkg::ST_OK;
    hit       = -1;
    free_slot = -1;
    // lowest active match wins; lowest free slot is the one a set claims
    for (int k = 0; k < kqt_pkg::TABLE_ENTRIES; k++) begin
      if (hit < 0 && shadow_valid[k] && shadow_owner[k] == req.owner) hit = k;
      if (free_slot < 0 && !shadow_valid[k]) free_slot = k;
    end
    res.found = (hit >= 0);

    case (req.action)
      kqt_pkg::ACT_SET: begin
        if (hit >= 0) begin
          shadow_inode_limit[hit] = req.inode_limit;
          shadow_block_limit[hit] = req.block_limit;
        end else if (free_slot < 0) begin
          res.status = kqt_pkg::ST_FULL;
        end else begin
          shadow_valid[free_slot]       = 1'b1;
          shadow_owner[free_slot]       = req.owner;
          shadow_inode_limit[free_slot] = req.inode_limit;
          shadow_block_limit[free_slot] = req.block_limit;
          shadow_inodes_used[free_slot] = '0;
          shadow_blocks_used[free_slot] = '0;
        end
      end
      kqt_pkg::ACT_CHK_INODE: begin
        if (hit >= 0 && shadow_inode_limit[hit] != 0 &&
            shadow_inodes_used[hit] >= shadow_inode_limit[hit])
          res.status = kqt_pkg::ST_EXCEEDED;
      end
      kqt_pkg::ACT_CHK_BLK: begin
        // 17-bit sum, so a large amount never wraps under the limit
        wide_sum = {1'b0, (hit >= 0) ? shadow_blocks_used[hit] : 16'd0} + {1'b0, req.amount};
        if (hit >= 0 && shadow_block_limit[hit] != 0 &&
            wide_sum > {1'b0, shadow_block_limit[hit]})
          res.status = kqt_pkg::ST_EXCEEDED;
      end
      kqt_pkg::ACT_ADD_INODE: begin
        if (hit >= 0 && shadow_inodes_used[hit] != 16'hFFFF)
          shadow_inodes_used[hit] = shadow_inodes_used[hit] + 16'd1;
      end
      kqt_pkg::ACT_RM_INODE: begin
        if (hit >= 0 && shadow_inodes_used[hit] != 16'd0)
          shadow_inodes_used[hit] = shadow_inodes_used[hit] - 16'd1;
      end
      kqt_pkg::ACT_ADD_BLK: begin
        if (hit >= 0) begin
          wide_sum = {1'b0, shadow_blocks_used[hit]} + {1'b0, req.amount};
          shadow_blocks_used[hit] = wide_sum[16] ? 16'hFFFF : wide_sum[15:0];
        end
      end
      kqt_pkg::ACT_RM_BLK: begin
        if (hit >= 0)
          shadow_blocks_used[hit] = (shadow_blocks_used[hit] >= req.amount) ?
                                    shadow_blocks_used[hit] - req.amount : 16'd0;
      end
      default: begin
        // get: entry fields only when there is an entry
        if (hit >= 0) begin
          res.inode_limit = shadow_inode_limit[hit];
          res.block_limit = shadow_block_limit[hit];
          res.inodes_used = shadow_inodes_used[hit];
          res.blocks_used = shadow_blocks_used[hit];
        end
      end
    endcase
    return res;
  endfunction

  // gap length: one draw in twenty takes the long range, the rest the short one
  function automatic int idle_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // limits lean small so checks actually trip, with the extremes and full range mixed in
  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(1, 6));
      5, 6:    return 16'($urandom_range(1, 2000));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_amount();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(1, 16));
      5, 6:    return 16'($urandom_range(0, 4096));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // mostly pooled owners so requests land on live entries; some unknown owners
  function automatic quota_req_t random_quota_request();
    quota_req_t req;

    req.action      = ($urandom_range(0, 99) < 12) ? kqt_pkg::ACT_SET
                                                   : 3'($urandom_range(1, 7));
    req.owner       = ($urandom_range(0, 99) < 85) ? owner_pool[$urandom_range(0, 19)]
                                                   : 16'($urandom_range(0, 65535));
    req.inode_limit = pick_limit();
    req.block_limit = pick_limit();
    req.amount      = pick_amount();
    return req;
  endfunction

  // drive one request, hold it until the block takes it, then record what it owes
  task automatic send_request(quota_req_t req);
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    action_i         <= req.action;
    owner_id_i       <= req.owner;
    inode_limit_in_i <= req.inode_limit;
    block_limit_in_i <= req.block_limit;
    block_amount_i   <= req.amount;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_quota(req));
    n_requests++;
    // ready stays low for the whole scan, so this dip costs no throughput
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    if (!no_idle && $urandom_range(0, 3) == 0) repeat (idle_len()) @(negedge clk_i);
  endtask

  task automatic issue(logic [2:0] act, logic [15:0] who, logic [15:0] ilim,
                       logic [15:0] blim, logic [15:0] amt);
    quota_req_t req;

    req = '{action: act, owner: who, inode_limit: ilim, block_limit: blim, amount: amt};
    send_request(req);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // field-by-field compare of every taken result against the oldest expectation
  always @(posedge clk_i) begin
    quota_result_t want;

    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d found %0d", status_o, found_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, status_o);
        check_field("found", want.found, found_o);
        check_field("inode_limit_out", want.inode_limit, inode_limit_out_o);
        check_field("block_limit_out", want.block_limit, block_limit_out_o);
        check_field("inodes_used_out", want.inodes_used, inodes_used_out_o);
        check_field("blocks_used_out", want.blocks_used, blocks_used_out_o);
        if (want.status == kqt_pkg::ST_EXCEEDED) n_exceeded++;
        if (want.status == kqt_pkg::ST_FULL) n_full++;
        if (want.found) n_found++;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off whenever hold_cycles is loaded
  initial begin
    int stall_left;

    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // extremes of every field, each action, and the named corner cases
  task automatic test_directed();
    // empty table: unknown owner is unlimited and has no entry
    issue(kqt_pkg::ACT_GET,       16'h0000, 16'h0000, 16'h0000, 16'h0000);
    issue(kqt_pkg::ACT_CHK_INODE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    issue(kqt_pkg::ACT_CHK_BLK,   16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    // two entries at the id extremes
    issue(kqt_pkg::ACT_SET,       16'h0000, 16'd2,    16'd100,  16'h0000);
    issue(kqt_pkg::ACT_SET,       16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // inode count up to the limit, then below zero
    issue(kqt_pkg::ACT_CHK_INODE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    issue(kqt_pkg::ACT_ADD_INODE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    issue(kqt_pkg::ACT_ADD_INODE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    issue(kqt_pkg::ACT_CHK_INODE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    issue(kqt_pkg::ACT_RM_INODE,  16'h0000, 16'h0000, 16'h0000, 16'h0000);
    issue(kqt_pkg::ACT_RM_INODE,  16'h0000, 16'h0000, 16'h0000, 16'h0000);
    issue(kqt_pkg::ACT_RM_INODE,  16'h0000, 16'h0000, 16'h0000, 16'h0000);
    issue(kqt_pkg::ACT_GET,       16'h0000, 16'h0000, 16'h0000, 16'h0000);
    // block count saturation, 17-bit check sum, floor on removal
    issue(kqt_pkg::ACT_ADD_BLK,   16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    issue(kqt_pkg::ACT_ADD_BLK,   16'hFFFF, 16'h0000, 16'h0000, 16'h0001);
    issue(kqt_pkg::ACT_CHK_BLK,   16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    issue(kqt_pkg::ACT_RM_BLK,    16'hFFFF, 16'h0000, 16'h0000, 16'h0001);
    issue(kqt_pkg::ACT_GET,       16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    issue(kqt_pkg::ACT_RM_BLK,    16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    // block check just over and exactly at the limit
    issue(kqt_pkg::ACT_CHK_BLK,   16'h0000, 16'h0000, 16'h0000, 16'd101);
    issue(kqt_pkg::ACT_CHK_BLK,   16'h0000, 16'h0000, 16'h0000, 16'd100);
    // update an existing entry to unlimited, then checks always pass
    issue(kqt_pkg::ACT_SET,       16'h0000, 16'h0000, 16'h0000, 16'h0000);
    issue(kqt_pkg::ACT_CHK_BLK,   16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    // unknown owner on the updating actions
    issue(kqt_pkg::ACT_ADD_INODE, 16'h1234, 16'h0000, 16'h0000, 16'h0000);
    issue(kqt_pkg::ACT_RM_BLK,    16'h1234, 16'h0000, 16'h0000, 16'h00FF);
  endtask

  task automatic test_random_traffic(int count, bit quiet);
    no_idle = quiet;
    repeat (count) send_request(random_quota_request());
    no_idle = 1'b0;
  endtask

  // receiver holds off for a long stretch while requests keep coming,
  // so the output register and the sequencer both fill and input stalls
  task automatic test_output_stall();
    hold_cycles = 300;
    no_idle = 1'b1;
    repeat (30) send_request(random_quota_request());
    no_idle = 1'b0;
  endtask

  // sender pauses until every owed result has come back
  task automatic test_drain_pause();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (kqt_pkg::TABLE_ENTRIES + 8) @(posedge clk_i);
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    action_i         = kqt_pkg::ACT_SET;
    owner_id_i       = '0;
    inode_limit_in_i = '0;
    block_limit_in_i = '0;
    block_amount_i   = '0;
    out_ready_i      = 1'b0;
    mismatches       = 0;
    hold_cycles      = 0;
    no_idle          = 1'b0;
    n_requests       = 0;
    n_results        = 0;
    n_exceeded       = 0;
    n_full           = 0;
    n_found          = 0;
    for (int k = 0; k < kqt_pkg::TABLE_ENTRIES; k++) begin
      shadow_valid[k]       = 1'b0;
      shadow_owner[k]       = '0;
      shadow_inode_limit[k] = '0;
      shadow_block_limit[k] = '0;
      shadow_inodes_used[k] = '0;
      shadow_blocks_used[k] = '0;
    end
    owner_pool[0] = 16'h0000;
    owner_pool[1] = 16'hFFFF;
    for (int k = 2; k < 20; k++) owner_pool[k] = 16'($urandom_range(1, 65534));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_traffic(600, 1'b0);
    test_random_traffic(200, 1'b1);
    test_output_stall();
    test_drain_pause();
    test_random_traffic(620, 1'b0);

    // wait out the last results and give the block room to misbehave
    test_drain_pause();

    $display("covered %0d requests, %0d results: %0d over quota, %0d table full, %0d hits",
             n_requests, n_results, n_exceeded, n_full, n_found);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(12 * 1000000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
